[rtl/arpc_pkg.sv]
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [1:0] OP_REPLY = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd0;

    localparam logic [0:0] KIND_PACKET = 1'b0;
    localparam logic [0:0] KIND_LOOKUP = 1'b1;

    localparam logic [2:0] ST_REPLIED = 3'd0;
    localparam logic [2:0] ST_BAD_HW = 3'd1;
    localparam logic [2:0] ST_BAD_PROTO = 3'd2;
    localparam logic [2:0] ST_NOT_FOR_US = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd5;
    localparam logic [2:0] ST_HIT = 3'd6;
    localparam logic [2:0] ST_MISS = 3'd7;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_CHECK,
        SEQ_FINISH
    } seq_state_t;

    typedef enum logic {
        CMP_SCAN,
        CMP_TARGET
    } cmp_sel_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_ip;
        logic [47:0]      wr_mac;
    } cache_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } cache_rsp_t;

endpackage

[rtl/arpc_cache.sv]
module arpc_cache (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arpc_pkg::cache_req_t req,
    output arpc_pkg::cache_rsp_t rsp
);

    logic [arpc_pkg::CACHE_ENTRIES-1:0] valid_reg;
    logic [31:0] ip_mem [arpc_pkg::CACHE_ENTRIES];
    logic [47:0] mac_mem [arpc_pkg::CACHE_ENTRIES];
    logic        rd_valid_reg;
    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            ip_mem[req.wr_addr] <= req.wr_ip;
            mac_mem[req.wr_addr] <= req.wr_mac;
        end
        if (req.rd_en)
        begin
            rd_ip_reg <= ip_mem[req.rd_addr];
            rd_mac_reg <= mac_mem[req.rd_addr];
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.ip = rd_ip_reg;
    assign rsp.mac = rd_mac_reg;

endmodule

[rtl/arpc_cmp.sv]
module arpc_cmp (
    input  arpc_pkg::cmp_sel_t sel,
    input  logic [31:0]        key,
    input  logic [31:0]        entry_ip,
    input  logic [31:0]        target_ip,
    input  logic [31:0]        own_ip,
    output logic               eq
);

    logic [31:0] op_a;
    logic [31:0] op_b;

    always_comb
    begin
        case (sel)
            arpc_pkg::CMP_SCAN:
            begin
                op_a = key;
                op_b = entry_ip;
            end
            arpc_pkg::CMP_TARGET:
            begin
                op_a = target_ip;
                op_b = own_ip;
            end
            default:
            begin
                op_a = key;
                op_b = entry_ip;
            end
        endcase
    end

    assign eq = (op_a == op_b);

endmodule

[rtl/arpc_seq.sv]
module arpc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [15:0]          hw_type,
    input  logic [15:0]          proto_type,
    input  logic [15:0]          arp_opcode,
    input  logic [47:0]          sender_mac,
    input  logic [31:0]          sender_ip,
    input  logic [31:0]          target_ip,
    input  logic [31:0]          lookup_ip,
    input  logic [31:0]          own_ip,
    input  logic [47:0]          own_mac,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [1:0]           reply_opcode,
    output logic [47:0]          reply_target_mac,
    output logic [31:0]          reply_target_ip,
    output logic [47:0]          reply_sender_mac,
    output logic [31:0]          reply_sender_ip,
    output logic [47:0]          found_mac,
    output arpc_pkg::cache_req_t cache_req,
    input  arpc_pkg::cache_rsp_t cache_rsp
);

    arpc_pkg::seq_state_t state_reg, state_next;
    logic                       kind_reg, kind_next;
    logic                       is_req_reg, is_req_next;
    logic [47:0]                smac_reg, smac_next;
    logic [31:0]                key_reg, key_next;
    logic [31:0]                tip_reg, tip_next;
    logic [2:0]                 stat_reg, stat_next;
    logic [arpc_pkg::IDX_W-1:0] scan_addr_reg, scan_addr_next;
    logic                       issue_done_reg, issue_done_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [arpc_pkg::IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                       hit_found_reg, hit_found_next;
    logic [arpc_pkg::IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]                hit_mac_reg, hit_mac_next;
    logic                       free_found_reg, free_found_next;
    logic [arpc_pkg::IDX_W-1:0] free_idx_reg, free_idx_next;

    logic                       out_valid_reg, out_valid_next;
    logic [2:0]                 o_status_reg, o_status_next;
    logic [1:0]                 o_op_reg, o_op_next;
    logic [47:0]                o_tmac_reg, o_tmac_next;
    logic [31:0]                o_tip_reg, o_tip_next;
    logic [47:0]                o_smac_reg, o_smac_next;
    logic [31:0]                o_sip_reg, o_sip_next;
    logic [47:0]                o_fmac_reg, o_fmac_next;

    arpc_pkg::cmp_sel_t cmp_sel;
    logic               eq;
    logic               match;

    arpc_cmp u_cmp (
        .sel       (cmp_sel),
        .key       (key_reg),
        .entry_ip  (cache_rsp.ip),
        .target_ip (tip_reg),
        .own_ip    (own_ip),
        .eq        (eq)
    );

    assign match = cmp_vld_reg && cache_rsp.valid && eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::SEQ_IDLE;
            issue_done_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_found_reg <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        is_req_reg <= is_req_next;
        smac_reg <= smac_next;
        key_reg <= key_next;
        tip_reg <= tip_next;
        stat_reg <= stat_next;
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_mac_reg <= hit_mac_next;
        free_idx_reg <= free_idx_next;
        o_status_reg <= o_status_next;
        o_op_reg <= o_op_next;
        o_tmac_reg <= o_tmac_next;
        o_tip_reg <= o_tip_next;
        o_smac_reg <= o_smac_next;
        o_sip_reg <= o_sip_next;
        o_fmac_reg <= o_fmac_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        is_req_next = is_req_reg;
        smac_next = smac_reg;
        key_next = key_reg;
        tip_next = tip_reg;
        stat_next = stat_reg;
        scan_addr_next = scan_addr_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next = hit_idx_reg;
        hit_mac_next = hit_mac_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_status_next = o_status_reg;
        o_op_next = o_op_reg;
        o_tmac_next = o_tmac_reg;
        o_tip_next = o_tip_reg;
        o_smac_next = o_smac_reg;
        o_sip_next = o_sip_reg;
        o_fmac_next = o_fmac_reg;
        in_ready = 1'b0;
        cmp_sel = arpc_pkg::CMP_SCAN;
        cache_req.rd_en = 1'b0;
        cache_req.rd_addr = scan_addr_reg;
        cache_req.wr_en = 1'b0;
        cache_req.wr_addr = free_idx_reg;
        cache_req.wr_ip = key_reg;
        cache_req.wr_mac = smac_reg;

        case (state_reg)
            arpc_pkg::SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next = kind;
                    is_req_next = (arp_opcode == arpc_pkg::OP_REQUEST);
                    smac_next = sender_mac;
                    tip_next = target_ip;
                    key_next = (kind == arpc_pkg::KIND_LOOKUP) ? lookup_ip : sender_ip;
                    scan_addr_next = '0;
                    issue_done_next = 1'b0;
                    hit_found_next = 1'b0;
                    free_found_next = 1'b0;
                    if (kind == arpc_pkg::KIND_LOOKUP)
                    begin
                        state_next = arpc_pkg::SEQ_SCAN;
                    end
                    else if (hw_type != arpc_pkg::HW_ETHERNET)
                    begin
                        stat_next = arpc_pkg::ST_BAD_HW;
                        state_next = arpc_pkg::SEQ_FINISH;
                    end
                    else if (proto_type != arpc_pkg::PROTO_IPV4)
                    begin
                        stat_next = arpc_pkg::ST_BAD_PROTO;
                        state_next = arpc_pkg::SEQ_FINISH;
                    end
                    else
                    begin
                        state_next = arpc_pkg::SEQ_SCAN;
                    end
                end
            end

            arpc_pkg::SEQ_SCAN:
            begin
                cache_req.rd_en = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_addr_reg;
                    if (scan_addr_reg == arpc_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + arpc_pkg::IDX_W'(1);
                    end
                end
                if (match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_mac_next = cache_rsp.mac;
                end
                if (cmp_vld_reg && !cache_rsp.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                if (cmp_vld_reg && cmp_idx_reg == arpc_pkg::LAST_IDX)
                begin
                    if (kind_reg == arpc_pkg::KIND_LOOKUP)
                    begin
                        stat_next = (hit_found_reg || match) ? arpc_pkg::ST_HIT
                                                             : arpc_pkg::ST_MISS;
                        state_next = arpc_pkg::SEQ_FINISH;
                    end
                    else
                    begin
                        state_next = arpc_pkg::SEQ_CHECK;
                    end
                end
            end

            arpc_pkg::SEQ_CHECK:
            begin
                cmp_sel = arpc_pkg::CMP_TARGET;
                cache_req.wr_addr = hit_found_reg ? hit_idx_reg : free_idx_reg;
                cache_req.wr_en = hit_found_reg || (eq && free_found_reg);
                if (!eq)
                begin
                    stat_next = arpc_pkg::ST_NOT_FOR_US;
                end
                else if (!hit_found_reg && !free_found_reg)
                begin
                    stat_next = arpc_pkg::ST_FULL;
                end
                else if (!is_req_reg)
                begin
                    stat_next = arpc_pkg::ST_BAD_OPCODE;
                end
                else
                begin
                    stat_next = arpc_pkg::ST_REPLIED;
                end
                state_next = arpc_pkg::SEQ_FINISH;
            end

            arpc_pkg::SEQ_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next = stat_reg;
                    if (stat_reg == arpc_pkg::ST_REPLIED)
                    begin
                        o_op_next = arpc_pkg::OP_REPLY;
                        o_tmac_next = smac_reg;
                        o_tip_next = key_reg;
                        o_smac_next = own_mac;
                        o_sip_next = own_ip;
                    end
                    else
                    begin
                        o_op_next = arpc_pkg::OP_NONE;
                        o_tmac_next = '0;
                        o_tip_next = '0;
                        o_smac_next = '0;
                        o_sip_next = '0;
                    end
                    o_fmac_next = (stat_reg == arpc_pkg::ST_HIT) ? hit_mac_reg : 48'd0;
                    state_next = arpc_pkg::SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = arpc_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status = o_status_reg;
    assign reply_opcode = o_op_reg;
    assign reply_target_mac = o_tmac_reg;
    assign reply_target_ip = o_tip_reg;
    assign reply_sender_mac = o_smac_reg;
    assign reply_sender_ip = o_sip_reg;
    assign found_mac = o_fmac_reg;

endmodule

[rtl/arp_responder_with_cache.sv]
// ARP responder with a sixteen-entry address cache.
// Input channel (in_valid/in_ready) takes one word: a parsed ARP packet
// (kind 0) or a cache lookup (kind 1). Output channel (out_valid/out_ready)
// gives exactly one result word per input word.
// Each word scans the cache one entry per cycle through a single registered
// read port and one shared 32-bit equality unit, which also checks the
// target address against own_ip. A lookup runs from accept through the scan
// to the result; a valid packet also passes the check state for the target
// check, and a packet with a bad hardware or protocol type skips the scan.
// in_ready is high only while the sequencer is idle, so one word is in work
// at a time and a new word is taken only once the last has left the sequencer.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds it and keeps in_ready low.
// Reset clears every cache valid bit, own_ip and own_mac at once; no
// clearing pass is needed. Registers are written over the APB port:
// own_ip at byte address 0, own_mac at byte address 8.
module arp_responder_with_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [arpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [arpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [15:0]                   hw_type,
    input  logic [15:0]                   proto_type,
    input  logic [15:0]                   arp_opcode,
    input  logic [47:0]                   sender_mac,
    input  logic [31:0]                   sender_ip,
    input  logic [31:0]                   target_ip,
    input  logic [31:0]                   lookup_ip,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [1:0]                    reply_opcode,
    output logic [47:0]                   reply_target_mac,
    output logic [31:0]                   reply_target_ip,
    output logic [47:0]                   reply_sender_mac,
    output logic [31:0]                   reply_sender_ip,
    output logic [47:0]                   found_mac
);

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic        cfg_wr;

    arpc_pkg::cache_req_t cache_req;
    arpc_pkg::cache_rsp_t cache_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
            begin
                own_mac_reg <= pwdata[47:0];
            end
            else
            begin
                own_ip_reg <= pwdata[31:0];
            end
        end
    end

    assign prdata = paddr[3] ? {16'd0, own_mac_reg} : {32'd0, own_ip_reg};

    arpc_cache u_cache (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cache_req),
        .rsp   (cache_rsp)
    );

    arpc_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .hw_type          (hw_type),
        .proto_type       (proto_type),
        .arp_opcode       (arp_opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_ip        (target_ip),
        .lookup_ip        (lookup_ip),
        .own_ip           (own_ip_reg),
        .own_mac          (own_mac_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .reply_opcode     (reply_opcode),
        .reply_target_mac (reply_target_mac),
        .reply_target_ip  (reply_target_ip),
        .reply_sender_mac (reply_sender_mac),
        .reply_sender_ip  (reply_sender_ip),
        .found_mac        (found_mac),
        .cache_req        (cache_req),
        .cache_rsp        (cache_rsp)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer stayed ready after accepting a word");

    a_reply_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != arpc_pkg::ST_REPLIED |->
            reply_opcode == arpc_pkg::OP_NONE && reply_target_mac == 48'd0 &&
            reply_sender_ip == 32'd0)
        else $error("reply fields set without a reply");

    a_found_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != arpc_pkg::ST_HIT |-> found_mac == 48'd0)
        else $error("found_mac set without a hit");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cache_req.rd_en |-> !cache_req.wr_en)
        else $error("cache written during scan");

endmodule
